// ===== hdl/wrg_pkg.sv =====
// wrg_pkg: types, request codes and constants of the WELL512 generator
// used by the interfaces, the ring, its cells, the top level and the checker
// no dependencies
package wrg_pkg;

    localparam int RING_DEPTH = 16;
    localparam int POS_W      = 4;
    localparam int WORD_W     = 32;
    localparam int VALUE_W    = 53;
    localparam int LOW_BITS   = 21;
    localparam int FUNC_W     = 2;

    // recurrence taps, relative to the current ring position
    localparam int TAP_A = 0;
    localparam int TAP_B = 13;
    localparam int TAP_C = 9;
    localparam int TAP_E = 15;

    localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hda44_2d24;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_SEED = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WORD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FRAC = 2'd2;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [FUNC_W-1:0]  func_t;

    // control from the top level to the ring
    typedef struct packed {
        logic  advance;
        logic  seed_en;
        pos_t  seed_slot;
        word_t seed_word;
    } ring_ctrl_t;

endpackage

// ===== hdl/wrg_in_if.sv =====
// wrg_in_if: request channel of the generator (valid/ready plus request word)
// depends on wrg_pkg
interface wrg_in_if;
    import wrg_pkg::*;

    logic  valid;
    logic  ready;
    func_t func;
    pos_t  seed_slot;
    word_t seed_word;

    modport source (output valid, output func, output seed_slot, output seed_word,
                    input ready);
    modport sink   (input valid, input func, input seed_slot, input seed_word,
                    output ready);
endinterface

// ===== hdl/wrg_out_if.sv =====
// wrg_out_if: result channel of the generator (valid/ready plus result word)
// depends on wrg_pkg
interface wrg_out_if;
    import wrg_pkg::*;

    logic   valid;
    logic   ready;
    value_t random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

// ===== hdl/wrg_cell.sv =====
// wrg_cell: one 32-bit word of the state ring, loaded from its neighbour or a seed
// depends on wrg_pkg
module wrg_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  wrg_pkg::word_t din,
    output wrg_pkg::word_t q
);
    import wrg_pkg::*;

    word_t word_reg;
    word_t word_next;

    // hold unless loaded
    always_comb
    begin
        word_next = load ? din : word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign q = word_reg;

endmodule

// ===== hdl/wrg_ring.sv =====
// wrg_ring: rotating row of sixteen cells with the WELL512 recurrence
// the current position always sits in cell 0; depends on wrg_pkg and wrg_cell
module wrg_ring (
    input  logic               clk,
    input  logic               rst_n,
    input  wrg_pkg::ring_ctrl_t ctrl,
    output wrg_pkg::word_t      new_word
);
    import wrg_pkg::*;

    word_t w [RING_DEPTH];
    word_t din [RING_DEPTH];
    logic  load [RING_DEPTH];

    pos_t  pos_reg;
    pos_t  pos_next;
    pos_t  seed_cell;

    word_t va, vb, vc0, vc, vd, ve0, b, c, a, d, e;

    // recurrence on the fixed taps
    always_comb
    begin
        va  = w[TAP_A];
        vb  = w[TAP_B];
        vc0 = w[TAP_C];
        ve0 = w[TAP_E];
        b   = va ^ vb ^ (va << 16) ^ (vb << 15);
        vc  = vc0 ^ (vc0 >> 11);
        c   = vc;
        a   = b ^ c;
        vd  = a ^ ((a << 5) & TEMPER_MASK);
        d   = vd;
        e   = ve0 ^ b ^ d ^ (ve0 << 2) ^ (b << 18) ^ (c << 28);
    end

    assign new_word = e;

    // absolute slot to physical cell
    assign seed_cell = ctrl.seed_slot - pos_reg;

    // position moves back by one on each advance
    always_comb
    begin
        pos_next = ctrl.advance ? pos_reg - pos_t'(1) : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // cell inputs: rotate on advance, seed word otherwise
    always_comb
    begin
        for (int k = 0; k < RING_DEPTH; k++)
        begin
            load[k] = ctrl.advance || (ctrl.seed_en && (seed_cell == pos_t'(k)));
            if (!ctrl.advance)
            begin
                din[k] = ctrl.seed_word;
            end
            else if (k == 0)
            begin
                din[k] = e;
            end
            else if (k == 1)
            begin
                din[k] = a;
            end
            else
            begin
                din[k] = w[(k + RING_DEPTH - 1) % RING_DEPTH];
            end
        end
    end

    // row of cells
    for (genvar g = 0; g < RING_DEPTH; g++)
    begin : g_cell
        wrg_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .load  (load[g]),
            .din   (din[g]),
            .q     (w[g])
        );
    end

endmodule

// ===== hdl/well512_random_generator_unit.sv =====
// well512_random_generator_unit: WELL512 generator top level
// one ring advance per cycle at most; a word draw shows its result in the cycle
// after acceptance; a fraction draw keeps its upper word, holds off requests
// for its second advance; seed loads and word draws one per cycle unless stalled
// reset: asynchronous, active low; ring words and position cleared to zero
module well512_random_generator_unit (
    input  logic      clk,
    input  logic      rst_n,
    wrg_in_if.sink    req,
    wrg_out_if.source rsp
);
    import wrg_pkg::*;

    ring_ctrl_t ctrl;
    word_t      new_word;

    logic   take_in;
    logic   out_free;
    logic   finish_frac;
    logic   is_seed, is_word, is_frac;

    logic   frac_busy_reg, frac_busy_next;
    word_t  hi_reg, hi_next;
    logic   out_valid_reg, out_valid_next;
    value_t out_value_reg, out_value_next;

    // handshake and decode
    assign out_free    = !out_valid_reg || rsp.ready;
    assign req.ready   = !frac_busy_reg && out_free;
    assign take_in     = req.valid && req.ready;
    assign is_seed     = (req.func == FUNC_SEED);
    assign is_word     = (req.func == FUNC_WORD);
    assign is_frac     = (req.func == FUNC_FRAC);
    assign finish_frac = frac_busy_reg && out_free;

    // ring control
    always_comb
    begin
        ctrl.advance   = (take_in && (is_word || is_frac)) || finish_frac;
        ctrl.seed_en   = take_in && is_seed;
        ctrl.seed_slot = req.seed_slot;
        ctrl.seed_word = req.seed_word;
    end

    wrg_ring u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .new_word (new_word)
    );

    // second half of a fraction draw and upper word
    always_comb
    begin
        frac_busy_next = frac_busy_reg;
        hi_next        = hi_reg;
        if (take_in && is_frac)
        begin
            frac_busy_next = 1'b1;
            hi_next        = new_word;
        end
        else if (finish_frac)
        begin
            frac_busy_next = 1'b0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        if (take_in && is_word)
        begin
            out_valid_next = 1'b1;
            out_value_next = {{(VALUE_W - WORD_W){1'b0}}, new_word};
        end
        else if (finish_frac)
        begin
            out_valid_next = 1'b1;
            out_value_next = {hi_reg, new_word[LOW_BITS-1:0]};
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frac_busy_reg <= frac_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg        <= hi_next;
        out_value_reg <= out_value_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.random_value = out_value_reg;

endmodule

// ===== hdl/wrg_checker.sv =====
// wrg_checker: port-level assertions for the WELL512 generator, bound to the top
// depends on wrg_pkg and well512_random_generator_unit
module wrg_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input wrg_pkg::func_t  req_func,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input wrg_pkg::value_t rsp_value
);
    import wrg_pkg::*;

    // no new word taken while a result is stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !req_ready)
        else $error("request taken while result stalled");

    // fraction draw holds off requests and results for its second advance
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_func == FUNC_FRAC) |=> (!req_ready && !rsp_valid))
        else $error("fraction draw second half overlapped");

    // word draw gives a 32-bit result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_func == FUNC_WORD)
        |=> (rsp_valid && rsp_value[VALUE_W-1:WORD_W] == '0))
        else $error("word draw result missing or too wide");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
        else $error("stalled result changed");

endmodule

bind well512_random_generator_unit wrg_checker u_wrg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_func  (req.func),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_value (rsp.random_value)
);

// ===== verif/tb.sv =====
// tb: self-checking bench for well512_random_generator_unit, with its own WELL512 ring model
// depends on wrg_pkg, wrg_in_if, wrg_out_if and the generator top level
// directed table first, then random seed loads and draws with random gaps and stalls
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wrg_pkg::*;

    // the selector value the block ignores
    localparam func_t FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1300;
    localparam int LONG_HOLD = 64;

    typedef struct packed {
        func_t  func;
        pos_t   slot;
        word_t  seed;
        logic   fixed;
        value_t value;
    } stim_row_t;

    typedef struct packed {
        logic   fixed;
        value_t value;
    } quote_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wrg_in_if  req_if ();
    wrg_out_if rsp_if ();

    well512_random_generator_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // model of the ring, reset state
    word_t ring_model [RING_DEPTH] = '{default: '0};
    pos_t  ring_at = '0;

    stim_row_t directed_rows [$];
    quote_t    offered_quotes [$];
    value_t    pending_values [$];

    logic steady = 1'b0;
    logic hold_request = 1'b0;
    int   n_seed = 0;
    int   n_word = 0;
    int   n_frac = 0;
    int   n_unused = 0;
    int   n_checked = 0;
    int   n_errors = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one WELL512 state advance on the model ring
    function automatic word_t well_advance();
        pos_t  p;
        pos_t  q;
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
        p = ring_at;
        a = ring_model[p];
        q = p + pos_t'(TAP_B);
        c = ring_model[q];
        b = a ^ c ^ (a << 16) ^ (c << 15);
        q = p + pos_t'(TAP_C);
        c = ring_model[q];
        c = c ^ (c >> 11);
        a = b ^ c;
        ring_model[p] = a;
        d = a ^ ((a << 5) & TEMPER_MASK);
        p = p + pos_t'(TAP_E);
        ring_at = p;
        e = ring_model[p];
        e = e ^ b ^ d ^ (e << 2) ^ (b << 18) ^ (c << 28);
        ring_model[p] = e;
        return e;
    endfunction

    // offer one request word, after a random gap
    task automatic offer_word(input func_t f, input pos_t s, input word_t w,
                              input logic fixed, input value_t v);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        offered_quotes.push_back(quote_t'{fixed, v});
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= f;
        req_if.seed_slot <= s;
        req_if.seed_word <= w;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // result check first, then prediction for an accepted request
    always @(posedge clk)
    begin : watch
        quote_t q;
        value_t want;
        value_t got;
        word_t  hi;
        word_t  lo;
        logic   gives;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.random_value;
                if (pending_values.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end
                else
                begin
                    want = pending_values.pop_front();
                    n_checked++;
                    if (got !== want)
                    begin
                        n_errors++;
                        $display("%0t: random_value mismatch, expected %h, actual %h",
                                 $time, want, got);
                    end
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                gives = 1'b0;
                want = '0;
                case (req_if.func)
                    FUNC_SEED:
                    begin
                        ring_model[req_if.seed_slot] = req_if.seed_word;
                        n_seed++;
                    end
                    FUNC_WORD:
                    begin
                        want = value_t'(well_advance());
                        gives = 1'b1;
                        n_word++;
                    end
                    FUNC_FRAC:
                    begin
                        hi = well_advance();
                        lo = well_advance();
                        want = {hi, lo[LOW_BITS-1:0]};
                        gives = 1'b1;
                        n_frac++;
                    end
                    default:
                        n_unused++;
                endcase
                q = offered_quotes.pop_front();
                if (gives)
                    pending_values.push_back(q.fixed ? q.value : want);
            end
        end
    end

    // result side: random stalls, the odd long hold-off
    initial
    begin : drain
        int stall;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (hold_request)
            begin
                stall = LONG_HOLD;
                hold_request <= 1'b0;
            end
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
        end
    end

    // request side: reset, directed table, random traffic, then drain and report
    initial
    begin : drive
        int    drawn;
        int    pick;
        func_t f;
        word_t w;
        req_if.valid     <= 1'b0;
        req_if.func      <= FUNC_SEED;
        req_if.seed_slot <= '0;
        req_if.seed_word <= '0;

        // unseeded ring gives zeros, seed fields ignored, unused selector ignored
        directed_rows.push_back('{FUNC_WORD, 4'd15, 32'hffff_ffff, 1'b1, value_t'(0)});
        directed_rows.push_back('{FUNC_FRAC, 4'd0, 32'h0000_0000, 1'b1, value_t'(0)});
        directed_rows.push_back('{FUNC_UNUSED, 4'd15, 32'hffff_ffff, 1'b0, value_t'(0)});
        // seed every slot, extremes at both ends
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            w = (i == 0) ? 32'hffff_ffff : (i == RING_DEPTH - 1) ? 32'h0 : 32'h9e37_79b9 * i;
            directed_rows.push_back('{FUNC_SEED, pos_t'(i), w, 1'b0, value_t'(0)});
        end
        directed_rows.push_back('{FUNC_WORD, 4'd0, 32'h0000_0000, 1'b0, value_t'(0)});
        directed_rows.push_back('{FUNC_FRAC, 4'd15, 32'hffff_ffff, 1'b0, value_t'(0)});
        directed_rows.push_back('{FUNC_UNUSED, 4'd0, 32'h0000_0000, 1'b0, value_t'(0)});
        // reseed mid-run without moving the position
        directed_rows.push_back('{FUNC_SEED, 4'd7, 32'hffff_ffff, 1'b0, value_t'(0)});
        directed_rows.push_back('{FUNC_FRAC, 4'd7, 32'h1234_5678, 1'b0, value_t'(0)});
        directed_rows.push_back('{FUNC_WORD, 4'd8, 32'h8765_4321, 1'b0, value_t'(0)});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_word(directed_rows[i].func, directed_rows[i].slot, directed_rows[i].seed,
                       directed_rows[i].fixed, directed_rows[i].value);

        // random mix: mostly draws, some reseeding, a few ignored selectors
        drawn = 0;
        while (drawn < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                f = FUNC_SEED;
            else if (pick < 20)
                f = FUNC_UNUSED;
            else if (pick < 60)
                f = FUNC_WORD;
            else
                f = FUNC_FRAC;
            if (f != FUNC_UNUSED)
            begin
                drawn++;
                if (drawn == 400 || drawn == 1000)
                begin
                    hold_request <= 1'b1;
                    steady <= 1'b1;
                end
                else if (drawn % 100 == 0)
                    steady <= ($urandom_range(0, 2) == 0);
            end
            offer_word(f, pos_t'($urandom_range(0, 15)), word_t'($urandom()), 1'b0,
                       value_t'(0));
        end
        req_if.valid <= 1'b0;
        steady <= 1'b0;

        @(posedge clk);
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d seed loads, %0d word draws, %0d fraction draws, %0d ignored",
                 n_seed, n_word, n_frac, n_unused);
        $display("%0d results compared, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/wrg_pkg.sv
hdl/wrg_in_if.sv
hdl/wrg_out_if.sv
hdl/wrg_cell.sv
hdl/wrg_ring.sv
hdl/well512_random_generator_unit.sv
hdl/wrg_checker.sv
verif/tb.sv
